FILE: hw/rtl/rotate_vector_about_axis_core_assert.svh
// assertion macros for the rotation core
// expects clk and rst_n in the scope where a macro is used
`ifndef ROTATE_VECTOR_ABOUT_AXIS_CORE_ASSERT_SVH
`define ROTATE_VECTOR_ABOUT_AXIS_CORE_ASSERT_SVH

// same-cycle implication
`define RVA_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication after a fixed number of cycles
`define RVA_CHECK_DELAY(label, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/rva_pkg.sv
// shared constants, types and tables of the rotation core
// no dependencies
package rva_pkg;

  localparam int COMP_WIDTH      = 32;
  localparam int FRAC_BITS       = 16;
  localparam int TRIG_ITERATIONS = 16;

  localparam int AXIS_W  = FRAC_BITS + 2;
  localparam int ANGLE_W = FRAC_BITS + 10;
  localparam int DEG_W   = FRAC_BITS + 8;   // folded angle, within +-90 degrees
  localparam int TW      = 34;              // cordic datapath, q2.30 with headroom
  localparam int RAD_W   = 26;

  localparam int TRIG_LAT = 2 + TRIG_ITERATIONS;
  localparam int LATENCY  = TRIG_LAT + 5;

  localparam logic signed [RAD_W-1:0] DEG_TO_RAD    = 26'sd18740330;
  localparam logic signed [TW-1:0]    TRIG_GAIN_INV = 34'sh026DD3B6A;
  localparam logic signed [TW-1:0]    TRIG_ONE      = 34'sh040000000;

  localparam logic signed [AXIS_W-1:0] AXIS_ONE = AXIS_W'(64'sd1 <<< FRAC_BITS);

  typedef struct packed {
    logic valid;
    logic neg;
  } trig_ctl_t;

  typedef struct packed {
    logic [COMP_WIDTH-1:0] vx;
    logic [COMP_WIDTH-1:0] vy;
    logic [COMP_WIDTH-1:0] vz;
    logic [AXIS_W-1:0]     kx;
    logic [AXIS_W-1:0]     ky;
    logic [AXIS_W-1:0]     kz;
  } vec_axis_t;

  function automatic logic signed [TW-1:0] atan_q30(input int i);
    logic signed [TW-1:0] a;
    case (i)
      0:  a = 34'sh03243F6A8;
      1:  a = 34'sh01DAC6705;
      2:  a = 34'sh00FADBAFC;
      3:  a = 34'sh007F56EA6;
      4:  a = 34'sh003FEAB76;
      5:  a = 34'sh001FFD55B;
      6:  a = 34'sh000FFFAAA;
      7:  a = 34'sh0007FFF55;
      8:  a = 34'sh0003FFFEA;
      9:  a = 34'sh0001FFFFD;
      10: a = 34'sh0000FFFFF;
      11: a = 34'sh00007FFFF;
      12: a = 34'sh00003FFFF;
      13: a = 34'sh00001FFFF;
      14: a = 34'sh00000FFFF;
      15: a = 34'sh000007FFF;
      16: a = 34'sh000003FFF;
      17: a = 34'sh000001FFF;
      18: a = 34'sh000000FFF;
      19: a = 34'sh0000007FF;
      20: a = 34'sh0000003FF;
      21: a = 34'sh0000001FF;
      22: a = 34'sh0000000FF;
      23: a = 34'sh00000007F;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic logic signed [AXIS_W-1:0] clamp_axis(input logic signed [AXIS_W-1:0] k);
    logic signed [AXIS_W-1:0] r;
    if (k > AXIS_ONE) begin
      r = AXIS_ONE;
    end else if (k < -AXIS_ONE) begin
      r = -AXIS_ONE;
    end else begin
      r = k;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/rva_angle.sv
// angle front end: clamp, fold to +-90 degrees, convert to q2.30 radians
// depends on rva_pkg
module rva_angle (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                req_valid,
  input  logic signed [rva_pkg::ANGLE_W-1:0]  angle_deg,
  output rva_pkg::trig_ctl_t                  ctl_out,
  output logic signed [rva_pkg::TW-1:0]       rad_out
);

  localparam int AW = rva_pkg::ANGLE_W;
  localparam int PW = rva_pkg::DEG_W + rva_pkg::RAD_W;
  localparam logic signed [AW-1:0] D90  = AW'(64'sd90 <<< rva_pkg::FRAC_BITS);
  localparam logic signed [AW-1:0] D180 = AW'(64'sd180 <<< rva_pkg::FRAC_BITS);
  localparam logic signed [AW-1:0] D360 = AW'(64'sd360 <<< rva_pkg::FRAC_BITS);

  logic signed [AW-1:0] d_clamp, d_wrap, d_fold;
  logic                 neg_nxt;
  logic signed [rva_pkg::DEG_W-1:0] deg_r;
  rva_pkg::trig_ctl_t   ctl_a_r, ctl_r;
  logic signed [PW-1:0] prod;
  logic signed [rva_pkg::TW-1:0] rad_r;

  always_comb begin
    if (angle_deg > D360) begin
      d_clamp = D360;
    end else if (angle_deg < -D360) begin
      d_clamp = -D360;
    end else begin
      d_clamp = angle_deg;
    end
    if (d_clamp > D180) begin
      d_wrap = d_clamp - D360;
    end else if (d_clamp < -D180) begin
      d_wrap = d_clamp + D360;
    end else begin
      d_wrap = d_clamp;
    end
    // past +-90 move by 180 and flip both sine and cosine
    neg_nxt = 1'b0;
    if (d_wrap > D90) begin
      d_fold  = d_wrap - D180;
      neg_nxt = 1'b1;
    end else if (d_wrap < -D90) begin
      d_fold  = d_wrap + D180;
      neg_nxt = 1'b1;
    end else begin
      d_fold = d_wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_r   <= '0;
    end else begin
      ctl_a_r <= '{valid: req_valid, neg: neg_nxt};
      ctl_r   <= ctl_a_r;
    end
  end

  assign prod = PW'(deg_r) * PW'(rva_pkg::DEG_TO_RAD);

  always_ff @(posedge clk) begin
    deg_r <= rva_pkg::DEG_W'(d_fold);
    rad_r <= rva_pkg::TW'(prod >>> rva_pkg::FRAC_BITS);
  end

  assign ctl_out = ctl_r;
  assign rad_out = rad_r;

endmodule

FILE: hw/rtl/rva_cordic.sv
// rotation-mode cordic, one iteration per pipeline stage
// depends on rva_pkg
module rva_cordic (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rva_pkg::trig_ctl_t            ctl_in,
  input  logic signed [rva_pkg::TW-1:0] rad_in,
  output rva_pkg::trig_ctl_t            ctl_out,
  output logic signed [rva_pkg::TW-1:0] cos_out,
  output logic signed [rva_pkg::TW-1:0] sin_out
);

  localparam int N  = rva_pkg::TRIG_ITERATIONS;
  localparam int TW = rva_pkg::TW;

  logic signed [TW-1:0] x_r [N];
  logic signed [TW-1:0] y_r [N];
  logic signed [TW-1:0] z_r [N];
  rva_pkg::trig_ctl_t   ctl_r [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [TW-1:0] xi, yi, zi;
    rva_pkg::trig_ctl_t   ci;
    if (i == 0) begin : g_first
      assign xi = rva_pkg::TRIG_GAIN_INV;
      assign yi = '0;
      assign zi = rad_in;
      assign ci = ctl_in;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign ci = ctl_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[i] <= '0;
      end else begin
        ctl_r[i] <= ci;
      end
    end

    always_ff @(posedge clk) begin
      if (zi[TW-1]) begin
        x_r[i] <= xi + (yi >>> i);
        y_r[i] <= yi - (xi >>> i);
        z_r[i] <= zi + rva_pkg::atan_q30(i);
      end else begin
        x_r[i] <= xi - (yi >>> i);
        y_r[i] <= yi + (xi >>> i);
        z_r[i] <= zi - rva_pkg::atan_q30(i);
      end
    end
  end

  assign ctl_out = ctl_r[N-1];
  assign cos_out = x_r[N-1];
  assign sin_out = y_r[N-1];

endmodule

FILE: hw/rtl/rva_combine.sv
// rodrigues combine: cross and dot products, three terms, sum and saturate
// depends on rva_pkg
module rva_combine (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  rva_pkg::trig_ctl_t                    ctl_in,
  input  logic signed [rva_pkg::TW-1:0]         cos_in,
  input  logic signed [rva_pkg::TW-1:0]         sin_in,
  input  rva_pkg::vec_axis_t                    va_in,
  output logic                                  res_valid,
  output logic signed [rva_pkg::COMP_WIDTH-1:0] res_x,
  output logic signed [rva_pkg::COMP_WIDTH-1:0] res_y,
  output logic signed [rva_pkg::COMP_WIDTH-1:0] res_z
);

  localparam int CW   = rva_pkg::COMP_WIDTH;
  localparam int KW   = rva_pkg::AXIS_W;
  localparam int TW   = rva_pkg::TW;
  localparam int F    = rva_pkg::FRAC_BITS;
  localparam int KVW  = KW + CW;
  localparam int CRW  = KVW + 1 - F;
  localparam int DW   = KVW + 2 - F;
  localparam int OW   = TW - 1;
  localparam int VCW  = CW + TW;
  localparam int CRSW = CRW + TW;
  localparam int DOMW = DW + OW;
  localparam int SCW  = DOMW - 28;
  localparam int KSW  = KW + SCW;
  localparam int TS   = 30 - F;
  localparam int ACCW = CRSW + 2;
  localparam logic signed [ACCW-1:0] MAXV = ACCW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [ACCW-1:0] MINV = -MAXV - ACCW'(1);

  logic signed [CW-1:0] v_in [3];
  logic signed [KW-1:0] k_in [3];

  assign v_in[0] = $signed(va_in.vx);
  assign v_in[1] = $signed(va_in.vy);
  assign v_in[2] = $signed(va_in.vz);
  assign k_in[0] = $signed(va_in.kx);
  assign k_in[1] = $signed(va_in.ky);
  assign k_in[2] = $signed(va_in.kz);

  logic [4:0] vld_r;

  // p1: nine axis-by-vector products, sign fix of the trig pair
  logic signed [KVW-1:0] kv1_r [3][3];
  logic signed [TW-1:0]  c1_r, s1_r;
  logic signed [CW-1:0]  v1_r [3];
  logic signed [KW-1:0]  k1_r [3];
  // p2: cross, dot, one minus cosine
  logic signed [CRW-1:0] cr2_r [3];
  logic signed [DW-1:0]  dot2_r;
  logic signed [OW-1:0]  omc2_r;
  logic signed [TW-1:0]  c2_r, s2_r;
  logic signed [CW-1:0]  v2_r [3];
  logic signed [KW-1:0]  k2_r [3];
  logic signed [TW:0]    omc_diff;
  // p3: trig products
  logic signed [VCW-1:0]  vc3_r [3];
  logic signed [CRSW-1:0] crs3_r [3];
  logic signed [DOMW-1:0] dom3_r;
  logic signed [KW-1:0]   k3_r [3];
  logic signed [SCW-1:0]  scal;
  // p4: aligned terms
  logic signed [ACCW-1:0] t1_4_r [3];
  logic signed [ACCW-1:0] t2_4_r [3];
  logic signed [KSW-1:0]  ks4_r [3];
  // p5: output
  logic signed [ACCW-1:0] acc [3];
  logic signed [ACCW-1:0] acc_sh [3];
  logic signed [CW-1:0]   rot_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], ctl_in.valid};
    end
  end

  // formed from the p1 cosine so that it lines up with the dot product
  assign omc_diff = (TW+1)'(rva_pkg::TRIG_ONE) - (TW+1)'(c1_r);
  assign scal     = SCW'(dom3_r >>> 28);

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc[j] = t1_4_r[j] + t2_4_r[j] + ACCW'(ks4_r[j]);
      acc_sh[j] = acc[j] >>> F;
    end
  end

  always_ff @(posedge clk) begin
    c1_r <= ctl_in.neg ? -cos_in : cos_in;
    s1_r <= ctl_in.neg ? -sin_in : sin_in;
    for (int j = 0; j < 3; j++) begin
      for (int m = 0; m < 3; m++) begin
        kv1_r[j][m] <= KVW'(k_in[j]) * KVW'(v_in[m]);
      end
      v1_r[j] <= v_in[j];
      k1_r[j] <= k_in[j];
    end

    cr2_r[0] <= CRW'(((KVW+1)'(kv1_r[1][2]) - (KVW+1)'(kv1_r[2][1])) >>> F);
    cr2_r[1] <= CRW'(((KVW+1)'(kv1_r[2][0]) - (KVW+1)'(kv1_r[0][2])) >>> F);
    cr2_r[2] <= CRW'(((KVW+1)'(kv1_r[0][1]) - (KVW+1)'(kv1_r[1][0])) >>> F);
    dot2_r   <= DW'(((KVW+2)'(kv1_r[0][0]) + (KVW+2)'(kv1_r[1][1])
                    + (KVW+2)'(kv1_r[2][2])) >>> F);
    c2_r <= c1_r;
    s2_r <= s1_r;
    v2_r <= v1_r;
    k2_r <= k1_r;
    omc2_r <= OW'(omc_diff >>> 2);

    for (int j = 0; j < 3; j++) begin
      vc3_r[j]  <= VCW'(v2_r[j]) * VCW'(c2_r);
      crs3_r[j] <= CRSW'(cr2_r[j]) * CRSW'(s2_r);
    end
    dom3_r <= DOMW'(dot2_r) * DOMW'(omc2_r);
    k3_r   <= k2_r;

    for (int j = 0; j < 3; j++) begin
      t1_4_r[j] <= ACCW'(vc3_r[j] >>> TS);
      t2_4_r[j] <= ACCW'(crs3_r[j] >>> TS);
      ks4_r[j]  <= KSW'(k3_r[j]) * KSW'(scal);
    end

    for (int j = 0; j < 3; j++) begin
      if (acc_sh[j] > MAXV) begin
        rot_r[j] <= CW'(MAXV);
      end else if (acc_sh[j] < MINV) begin
        rot_r[j] <= CW'(MINV);
      end else begin
        rot_r[j] <= CW'(acc_sh[j]);
      end
    end
  end

  assign res_valid = vld_r[4];
  assign res_x     = rot_r[0];
  assign res_y     = rot_r[1];
  assign res_z     = rot_r[2];

endmodule

FILE: hw/rtl/rotate_vector_about_axis_core.sv
// Rotates a Q16.16 vector about a unit axis by an angle in Q10.16 degrees (Rodrigues).
// A request is taken on every cycle that start is high; busy is always low. Each result
// appears on out_valid and out_rot_* in request order, one result per request, after the
// request has passed the angle front end, the 16-stage cordic and the five-stage
// product/sum pipeline. The receiver cannot stall, so results must be taken in the
// cycle they are shown.
// depends on rva_pkg, rva_angle, rva_cordic, rva_combine and the assert header
module rotate_vector_about_axis_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [rva_pkg::COMP_WIDTH-1:0]  in_vec_x,
  input  logic signed [rva_pkg::COMP_WIDTH-1:0]  in_vec_y,
  input  logic signed [rva_pkg::COMP_WIDTH-1:0]  in_vec_z,
  input  logic signed [rva_pkg::AXIS_W-1:0]      in_axis_x,
  input  logic signed [rva_pkg::AXIS_W-1:0]      in_axis_y,
  input  logic signed [rva_pkg::AXIS_W-1:0]      in_axis_z,
  input  logic signed [rva_pkg::ANGLE_W-1:0]     in_angle_deg,
  output logic                                   out_valid,
  output logic signed [rva_pkg::COMP_WIDTH-1:0]  out_rot_x,
  output logic signed [rva_pkg::COMP_WIDTH-1:0]  out_rot_y,
  output logic signed [rva_pkg::COMP_WIDTH-1:0]  out_rot_z
);

`include "rotate_vector_about_axis_core_assert.svh"

  localparam int LAT = rva_pkg::LATENCY;
  localparam int DL  = rva_pkg::TRIG_LAT;

  rva_pkg::trig_ctl_t             ang_ctl, trig_ctl;
  logic signed [rva_pkg::TW-1:0]  rad, cos_v, sin_v;
  rva_pkg::vec_axis_t             va_nxt;
  rva_pkg::vec_axis_t             va_r [DL];
  logic                           in_zero, out_zero;

  assign busy = 1'b0;

  assign va_nxt = '{vx: in_vec_x, vy: in_vec_y, vz: in_vec_z,
                    kx: rva_pkg::clamp_axis(in_axis_x),
                    ky: rva_pkg::clamp_axis(in_axis_y),
                    kz: rva_pkg::clamp_axis(in_axis_z)};

  // vector and axis wait here while sine and cosine are formed
  always_ff @(posedge clk) begin
    va_r[0] <= va_nxt;
    for (int i = 1; i < DL; i++) begin
      va_r[i] <= va_r[i-1];
    end
  end

  rva_angle u_angle (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (start),
    .angle_deg (in_angle_deg),
    .ctl_out   (ang_ctl),
    .rad_out   (rad)
  );

  rva_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (ang_ctl),
    .rad_in  (rad),
    .ctl_out (trig_ctl),
    .cos_out (cos_v),
    .sin_out (sin_v)
  );

  rva_combine u_combine (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_in    (trig_ctl),
    .cos_in    (cos_v),
    .sin_in    (sin_v),
    .va_in     (va_r[DL-1]),
    .res_valid (out_valid),
    .res_x     (out_rot_x),
    .res_y     (out_rot_y),
    .res_z     (out_rot_z)
  );

  assign in_zero  = ~|{in_vec_x, in_vec_y, in_vec_z};
  assign out_zero = ~|{out_rot_x, out_rot_y, out_rot_z};

  `RVA_CHECK_DELAY(a_req_gives_result, start, LAT, out_valid, "request produced no result")
  `RVA_CHECK(a_result_has_req, out_valid, $past(start, LAT), "result without a request")
  `RVA_CHECK(a_zero_vec, out_valid && $past(in_zero, LAT), out_zero, "zero vector not kept zero")

endmodule

FILE: tb/rotate_vector_about_axis_checker.sv
// checker for the rotation core: predicts each rotation from the request ports
// and compares it with the result strobe; depends on rva_pkg
module rotate_vector_about_axis_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic                                  busy,
  input  logic signed [rva_pkg::COMP_WIDTH-1:0] in_vec_x,
  input  logic signed [rva_pkg::COMP_WIDTH-1:0] in_vec_y,
  input  logic signed [rva_pkg::COMP_WIDTH-1:0] in_vec_z,
  input  logic signed [rva_pkg::AXIS_W-1:0]     in_axis_x,
  input  logic signed [rva_pkg::AXIS_W-1:0]     in_axis_y,
  input  logic signed [rva_pkg::AXIS_W-1:0]     in_axis_z,
  input  logic signed [rva_pkg::ANGLE_W-1:0]    in_angle_deg,
  input  logic                                  out_valid,
  input  logic signed [rva_pkg::COMP_WIDTH-1:0] out_rot_x,
  input  logic signed [rva_pkg::COMP_WIDTH-1:0] out_rot_y,
  input  logic signed [rva_pkg::COMP_WIDTH-1:0] out_rot_z,
  output int                                    fail_count,
  output int                                    pending_count
);
  import rva_pkg::*;

  typedef struct {
    logic signed [COMP_WIDTH-1:0] x;
    logic signed [COMP_WIDTH-1:0] y;
    logic signed [COMP_WIDTH-1:0] z;
  } rot_vec_t;

  rot_vec_t rotated_q[$];

  localparam longint ONE_F = 64'sd1 << FRAC_BITS;
  localparam longint SAT_HI = (64'sd1 <<< (COMP_WIDTH - 1)) - 1;
  localparam longint SAT_LO = -(64'sd1 <<< (COMP_WIDTH - 1));
  localparam longint INV_GAIN = 64'sh26DD3B6A;
  localparam longint UNIT_Q30 = 64'sd1073741824;
  localparam longint RAD_PER_DEG = 64'sd18740330;

  function automatic longint limit(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint atan_step(int i);
    longint t[24] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                      64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
                      64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
    return t[i];
  endfunction

  task automatic sin_cos(input longint deg_in, output longint c, output longint s);
    longint d90, d180, d360, deg, x, y, z, nx;
    bit flip;
    d90 = 64'sd90 <<< FRAC_BITS;
    d180 = 64'sd180 <<< FRAC_BITS;
    d360 = 64'sd360 <<< FRAC_BITS;
    flip = 0;
    deg = limit(deg_in, -d360, d360);
    if (deg > d180) deg -= d360;
    else if (deg < -d180) deg += d360;
    if (deg > d90) begin
      deg -= d180;
      flip = 1;
    end else if (deg < -d90) begin
      deg += d180;
      flip = 1;
    end
    z = (deg * RAD_PER_DEG) >>> FRAC_BITS;
    x = INV_GAIN;
    y = 0;
    for (int i = 0; i < TRIG_ITERATIONS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_step(i);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_step(i);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic predict_rotation(output rot_vec_t r);
    longint v[3], k[3], cr[3], res[3];
    longint c, s, dot, omc, scal, acc;
    v[0] = in_vec_x;
    v[1] = in_vec_y;
    v[2] = in_vec_z;
    k[0] = limit(in_axis_x, -ONE_F, ONE_F);
    k[1] = limit(in_axis_y, -ONE_F, ONE_F);
    k[2] = limit(in_axis_z, -ONE_F, ONE_F);
    sin_cos(longint'(in_angle_deg), c, s);
    cr[0] = (k[1] * v[2] - k[2] * v[1]) >>> FRAC_BITS;
    cr[1] = (k[2] * v[0] - k[0] * v[2]) >>> FRAC_BITS;
    cr[2] = (k[0] * v[1] - k[1] * v[0]) >>> FRAC_BITS;
    dot = (k[0] * v[0] + k[1] * v[1] + k[2] * v[2]) >>> FRAC_BITS;
    omc = (UNIT_Q30 - c) >>> 2;
    scal = (dot * omc) >>> 28;
    for (int j = 0; j < 3; j++) begin
      acc = ((v[j] * c) >>> (30 - FRAC_BITS)) + ((cr[j] * s) >>> (30 - FRAC_BITS))
          + k[j] * scal;
      res[j] = limit(acc >>> FRAC_BITS, SAT_LO, SAT_HI);
    end
    r.x = res[0][COMP_WIDTH-1:0];
    r.y = res[1][COMP_WIDTH-1:0];
    r.z = res[2][COMP_WIDTH-1:0];
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    rot_vec_t e;
    if (rst_n && start && !busy) begin
      predict_rotation(e);
      rotated_q.push_back(e);
    end
    if (rst_n && out_valid) begin
      if (rotated_q.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        e = rotated_q.pop_front();
        if (out_rot_x !== e.x) begin
          $error("rot_x expected %0d actual %0d", e.x, out_rot_x);
          fail_count++;
        end
        if (out_rot_y !== e.y) begin
          $error("rot_y expected %0d actual %0d", e.y, out_rot_y);
          fail_count++;
        end
        if (out_rot_z !== e.z) begin
          $error("rot_z expected %0d actual %0d", e.z, out_rot_z);
          fail_count++;
        end
      end
    end
    pending_count = rotated_q.size();
  end
endmodule

FILE: tb/tb_top.sv
// top of the rotation core testbench: clock, reset, request stimulus, verdict
// depends on rva_pkg, rotate_vector_about_axis_core and the checker
module tb_top;
  import rva_pkg::*;

  logic clk, rst_n, start, busy, out_valid;
  logic signed [COMP_WIDTH-1:0] in_vec_x, in_vec_y, in_vec_z;
  logic signed [AXIS_W-1:0] in_axis_x, in_axis_y, in_axis_z;
  logic signed [ANGLE_W-1:0] in_angle_deg;
  logic signed [COMP_WIDTH-1:0] out_rot_x, out_rot_y, out_rot_z;
  int fail_count, pending_count, idle_cycles;
  int idle_pct;

  localparam int WATCHDOG = 2000;
  localparam int ANG360 = 360 << FRAC_BITS;

  rotate_vector_about_axis_core dut (.*);
  rotate_vector_about_axis_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [31:0] rand_vec_comp();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000;
      2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000;
    endcase
  endfunction

  function automatic logic [AXIS_W-1:0] rand_axis();
    if ($urandom_range(0, 9) == 0) return AXIS_W'($urandom());
    return AXIS_W'($signed($urandom_range(0, 131072)) - 65536);
  endfunction

  // each cycle stays idle with probability idle_pct percent
  task automatic send(input logic [31:0] vx, vy, vz, input logic [AXIS_W-1:0] kx, ky, kz,
                      input logic [ANGLE_W-1:0] ang);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_vec_x <= vx; in_vec_y <= vy; in_vec_z <= vz;
    in_axis_x <= kx; in_axis_y <= ky; in_axis_z <= kz;
    in_angle_deg <= ang;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [ANGLE_W-1:0] a;
    start = 1'b0; rst_n = 1'b0; idle_cycles = 0; idle_pct = 0;
    in_vec_x = '0; in_vec_y = '0; in_vec_z = '0;
    in_axis_x = '0; in_axis_y = '0; in_axis_z = '0; in_angle_deg = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed: field extremes, fold boundaries, clamps
    send(32'h7FFFFFFF, 32'h80000000, 32'h00010000, 18'sd65536, '0, '0, '0);
    send(32'h00010000, '0, '0, '0, '0, 18'sd65536, 26'(90 << 16));
    send(32'h00010000, '0, '0, '0, '0, 18'sd65536, 26'(-90 << 16));
    send(32'h00010000, 32'h00020000, '0, '0, '0, 18'sd65536, 26'(180 << 16));
    send(32'h00010000, 32'h00020000, '0, '0, '0, -18'sd65536, 26'(-180 << 16));
    send(32'h00010000, '0, 32'h00030000, '0, 18'sd65536, '0, 26'(ANG360));
    send(32'h00010000, '0, 32'h00030000, '0, 18'sd65536, '0, 26'(-ANG360));
    send(32'h00010000, 32'hFFFF0000, '0, 18'h1FFFF, 18'h20000, '0, 26'h1FFFFFF);
    send(32'h00010000, 32'hFFFF0000, '0, 18'h20000, 18'h1FFFF, '0, 26'h2000000);
    send(32'h80000000, 32'h80000000, 32'h80000000, -18'sd65536, -18'sd65536,
         -18'sd65536, 26'(45 << 16));
    send(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 18'sd65536, 18'sd65536,
         18'sd65536, 26'(135 << 16));
    send(32'hFFFFFFFF, 32'd1, '0, 18'sd46341, 18'sd46341, '0, 26'((91 << 16) + 1));
    send(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 18'sd37837, 18'sd37837,
         18'sd37837, 26'((270 << 16) + 12345));
    send(32'h00050000, 32'h00000000, 32'hFFFB0000, '0, 18'sd65536, '0, 26'((181 << 16)));
    send('0, '0, '0, '0, '0, '0, 26'h3FFFFFF);
    // phases: no idling, sender idle 80, no idling, sender idle 12
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 80 : (ph == 3) ? 12 : 0;
      for (int n = 0; n < 475; n++) begin
        case ($urandom_range(0, 4))
          0: a = ANGLE_W'($urandom());
          1: a = 26'($signed($urandom_range(0, 2 * ANG360)) - ANG360);
          2: a = 26'($signed($urandom_range(0, 8)) * (45 << 16)
                  - (180 << 16) + $signed($urandom_range(0, 2)) - 1);
          default: a = 26'($signed($urandom_range(0, 2 * ANG360)) - ANG360);
        endcase
        send(rand_vec_comp(), rand_vec_comp(), rand_vec_comp(),
             rand_axis(), rand_axis(), rand_axis(), a);
      end
    end
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
